// ----- hw/rtl/bpwt_pkg.sv -----
package bpwt_pkg;

    localparam int SLOTS_DEF     = 16;
    localparam int TIME_BITS_DEF = 16;
    localparam int ID_W          = 8;
    localparam int WAIT_W        = 16;
    localparam int STATUS_W      = 2;

    typedef enum logic [STATUS_W-1:0] {
        ST_ACCEPT  = 2'd0,
        ST_FULL    = 2'd1,
        ST_RELEASE = 2'd2,
        ST_NONE    = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BLOCK,
        S_READ,
        S_PROC,
        S_FINISH
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;        // capture input item, set up walk pointers
        logic blk_commit;  // append entry (or reject) and emit its result
        logic rd;          // read entry at walk pointer
        logic proc;        // consume read entry: keep or release
        logic fin;         // emit closing result, commit new window
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic in_cmd;       // 1 = tick
        logic count_zero;
        logic out_free;
        logic rel;          // entry on read port is due for release
        logic pend_valid;   // a release is held back for the last flag
        logic remain_last;  // entry on read port is the oldest one
    } t_dp_status;

endpackage

// ----- hw/rtl/bpwt_ram.sv -----
module bpwt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/bpwt_ctrl.sv -----
module bpwt_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  bpwt_pkg::t_dp_status  i_st,
    output bpwt_pkg::t_dp_cmd     o_cmd,
    output logic                  o_in_ready
);
    import bpwt_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   stall;

    // a second release cannot displace the held one until the output frees
    assign stall = i_st.rel && i_st.pend_valid && !i_st.out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (!i_st.in_cmd) begin
                        n_state = S_BLOCK;
                    end else if (i_st.count_zero) begin
                        n_state = S_FINISH;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_BLOCK: begin
                if (i_st.out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_READ: begin
                n_state = S_PROC;
            end
            S_PROC: begin
                if (!stall) begin
                    n_state = i_st.remain_last ? S_FINISH : S_READ;
                end
            end
            S_FINISH: begin
                if (i_st.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_BLOCK:  o_cmd.blk_commit = i_st.out_free;
            S_READ:   o_cmd.rd         = 1'b1;
            S_PROC:   o_cmd.proc       = !stall;
            S_FINISH: o_cmd.fin        = i_st.out_free;
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// ----- hw/rtl/bpwt_dp.sv -----
module bpwt_dp #(
    parameter int SLOTS     = bpwt_pkg::SLOTS_DEF,
    parameter int TIME_BITS = bpwt_pkg::TIME_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  bpwt_pkg::t_dp_cmd              i_cmd_dp,
    output bpwt_pkg::t_dp_status           o_st,
    input  logic                           i_cmd,
    input  logic [bpwt_pkg::ID_W-1:0]      i_process_id,
    input  logic [bpwt_pkg::WAIT_W-1:0]    i_sleep_ticks,
    input  logic                           i_has_credit,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [bpwt_pkg::STATUS_W-1:0]  o_status,
    output logic [bpwt_pkg::ID_W-1:0]      o_released_id,
    output logic                           o_last
);
    import bpwt_pkg::*;

    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int SW = IW + 2;
    localparam int MW = ID_W + TIME_BITS + 1;

    function automatic logic [IW-1:0] idx_dec(input logic [IW-1:0] a);
        logic [IW-1:0] res;
        if (a == '0) begin
            res = IW'(SLOTS - 1);
        end else begin
            res = a - 1'b1;
        end
        return res;
    endfunction

    function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] a);
        logic [IW-1:0] res;
        if (a == IW'(SLOTS - 1)) begin
            res = '0;
        end else begin
            res = a + 1'b1;
        end
        return res;
    endfunction

    // live entries sit at base .. base+count-1 (circular), oldest first
    logic [IW-1:0]      r_base;
    logic [CW-1:0]      r_count;
    logic [IW-1:0]      r_rptr;
    logic [IW-1:0]      r_wptr;
    logic [CW-1:0]      r_remain;
    logic [CW-1:0]      r_kept;
    logic               r_pend_valid;
    logic [ID_W-1:0]    r_pend_id;
    logic               r_in_cmd;
    logic [ID_W-1:0]    r_in_id;
    logic [TIME_BITS-1:0] r_in_wait;
    logic               r_in_credit;
    logic               r_out_valid;
    t_status            r_status;
    logic [ID_W-1:0]    r_out_id;
    logic               r_last;

    logic [SW-1:0]      sum;
    logic [IW-1:0]      app_idx;
    logic               full;
    logic [MW-1:0]      rdata;
    logic [ID_W-1:0]    rd_id;
    logic [TIME_BITS-1:0] rd_cnt;
    logic               rd_credit;
    logic [TIME_BITS-1:0] dec_cnt;
    logic               rel;
    logic               out_free;
    logic               mem_we;
    logic [IW-1:0]      mem_waddr;
    logic [MW-1:0]      mem_wdata;
    logic               keep;
    logic               emit_mid;

    assign sum     = SW'(r_base) + SW'(r_count);
    assign app_idx = (sum >= SW'(SLOTS)) ? IW'(sum - SW'(SLOTS)) : IW'(sum);
    assign full    = (r_count == CW'(SLOTS));

    assign {rd_id, rd_cnt, rd_credit} = rdata;
    assign dec_cnt  = (rd_cnt == '0) ? '0 : rd_cnt - 1'b1;
    assign rel      = (dec_cnt == '0) && rd_credit;
    assign out_free = !r_out_valid || i_out_ready;
    assign keep     = i_cmd_dp.proc && !rel;
    assign emit_mid = i_cmd_dp.proc && rel && r_pend_valid;

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_wptr;
        mem_wdata = {rd_id, dec_cnt, rd_credit};
        if (i_cmd_dp.blk_commit && !full) begin
            mem_we    = 1'b1;
            mem_waddr = app_idx;
            mem_wdata = {r_in_id, r_in_wait, r_in_credit};
        end else if (keep) begin
            mem_we = 1'b1;
        end
    end

    bpwt_ram #(
        .WIDTH (MW),
        .DEPTH (SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (i_cmd_dp.rd),
        .i_raddr (r_rptr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base       <= '0;
            r_count      <= '0;
            r_pend_valid <= 1'b0;
        end else begin
            if (i_cmd_dp.load) begin
                r_pend_valid <= 1'b0;
            end
            if (i_cmd_dp.blk_commit && !full) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd_dp.proc && rel) begin
                r_pend_valid <= 1'b1;
            end
            if (i_cmd_dp.fin) begin
                r_base       <= idx_inc(r_wptr);
                r_count      <= r_kept;
                r_pend_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd_dp.load) begin
            r_in_cmd    <= i_cmd;
            r_in_id     <= i_process_id;
            r_in_wait   <= TIME_BITS'(i_sleep_ticks);
            r_in_credit <= i_has_credit;
            r_rptr      <= idx_dec(app_idx);
            r_wptr      <= idx_dec(app_idx);
            r_remain    <= r_count;
            r_kept      <= '0;
        end
        if (i_cmd_dp.proc) begin
            r_rptr   <= idx_dec(r_rptr);
            r_remain <= r_remain - 1'b1;
            if (rel) begin
                r_pend_id <= rd_id;
            end else begin
                r_wptr <= idx_dec(r_wptr);
                r_kept <= r_kept + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd_dp.blk_commit || emit_mid || i_cmd_dp.fin) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd_dp.blk_commit) begin
            r_status <= full ? ST_FULL : ST_ACCEPT;
            r_out_id <= '0;
            r_last   <= 1'b1;
        end else if (emit_mid) begin
            r_status <= ST_RELEASE;
            r_out_id <= r_pend_id;
            r_last   <= 1'b0;
        end else if (i_cmd_dp.fin) begin
            r_status <= r_pend_valid ? ST_RELEASE : ST_NONE;
            r_out_id <= r_pend_valid ? r_pend_id : '0;
            r_last   <= 1'b1;
        end
    end

    assign o_st.in_cmd      = i_cmd;
    assign o_st.count_zero  = (r_count == '0);
    assign o_st.out_free    = out_free;
    assign o_st.rel         = rel;
    assign o_st.pend_valid  = r_pend_valid;
    assign o_st.remain_last = (r_remain == CW'(1)) || !r_in_cmd;

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_released_id = r_out_id;
    assign o_last        = r_last;

endmodule

// ----- hw/rtl/blocked_process_wait_table.sv -----
// A block item moves from IDLE to BLOCK, which registers its result once the output is
// free. A tick reads, then updates, each entry of the table RAM in turn (READ, PROC),
// then closes in FINISH; these steps are held while the output stalls. Only one item is
// handled at a time: a new one is taken only in IDLE, once the last one is done.
// Reset (synchronous, active low) empties the table at once: no clearing pass.
module blocked_process_wait_table #(
    parameter int SLOTS     = bpwt_pkg::SLOTS_DEF,
    parameter int TIME_BITS = bpwt_pkg::TIME_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_cmd,
    input  logic [bpwt_pkg::ID_W-1:0]     i_process_id,
    input  logic [bpwt_pkg::WAIT_W-1:0]   i_sleep_ticks,
    input  logic                          i_has_credit,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [bpwt_pkg::STATUS_W-1:0] o_status,
    output logic [bpwt_pkg::ID_W-1:0]     o_released_id,
    output logic                          o_last
);
    import bpwt_pkg::*;

    // The table lives in one RAM as a circular window, oldest entry at the
    // base. A block transfer appends at the newest end. A tick walks from the
    // newest end down; kept entries are written back, packed, behind the
    // read pointer, so the window closes up toward the newest end and the
    // base moves past the freed slots when the walk is done.
    //
    // Each release is held one step so the final one can carry the last
    // flag; a tick that frees nothing closes with a "none" result.

    t_dp_cmd    dp_cmd;
    t_dp_status dp_st;

    bpwt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_st       (dp_st),
        .o_cmd      (dp_cmd),
        .o_in_ready (o_in_ready)
    );

    bpwt_dp #(
        .SLOTS     (SLOTS),
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_dp      (dp_cmd),
        .o_st          (dp_st),
        .i_cmd         (i_cmd),
        .i_process_id  (i_process_id),
        .i_sleep_ticks (i_sleep_ticks),
        .i_has_credit  (i_has_credit),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_released_id (o_released_id),
        .o_last        (o_last)
    );

endmodule

// ----- verif/blocked_process_wait_table_tb.sv -----
`timescale 1ns / 100ps

module blocked_process_wait_table_tb;
    import bpwt_pkg::*;

    // Command codes carried on i_cmd
    localparam logic CMD_BLOCK = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    localparam int TABLE_SLOTS    = SLOTS_DEF;
    localparam int RAND_ITEMS     = 96;
    localparam int MAX_REPORTS    = 10;
    // Receiver hold-off: start once this many results are in, then hold for a long stretch
    localparam int HOLD_AT        = 70;
    localparam int HOLD_CYCLES    = 400;
    // Longest transfer-free stretch of a correct run is the hold-off plus one full tick
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 2 * TABLE_SLOTS + 20;
    // Random waits stay short so entries cycle through the table
    localparam int SHORT_WAIT     = 6;
    localparam int LONG_WAIT      = 1024;
    // Cap on entries that never leave (no credit or very long wait)
    localparam int STUCK_CAP      = 8;

    typedef struct packed {
        logic [ID_W-1:0]          pid;
        logic [TIME_BITS_DEF-1:0] ticks_left;
        logic                     credit;
    } t_sleeper;

    typedef struct packed {
        t_status         status;
        logic [ID_W-1:0] rid;
        logic            last;
    } t_result;

    // One row of the directed table. Rows with by_hand set carry their single
    // expected result (id 0, last 1); the rest go through the predictor.
    typedef struct packed {
        logic              cmd;
        logic [ID_W-1:0]   pid;
        logic [WAIT_W-1:0] sleep_ticks;
        logic              credit;
        logic              by_hand;
        t_status           status;
    } t_plan_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    logic                i_cmd;
    logic [ID_W-1:0]     i_process_id;
    logic [WAIT_W-1:0]   i_sleep_ticks;
    logic                i_has_credit;
    logic                o_out_valid;
    logic                i_out_ready;
    logic [STATUS_W-1:0] o_status;
    logic [ID_W-1:0]     o_released_id;
    logic                o_last;

    t_sleeper  sleepers[$];       // blocked processes as the block should hold them, oldest first
    t_result   item_results[$];   // results predicted for the item just transferred
    t_result   due_results[$];    // results still owed by the block, oldest first
    t_plan_row plan[$];

    int n_bad       = 0;
    int n_checked   = 0;
    int idle_cycles = 0;
    int burst_left  = 0;
    bit hold_done   = 1'b0;

    blocked_process_wait_table dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_cmd         (i_cmd),
        .i_process_id  (i_process_id),
        .i_sleep_ticks (i_sleep_ticks),
        .i_has_credit  (i_has_credit),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_released_id (o_released_id),
        .o_last        (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_result mk_result(input t_status st, input logic [ID_W-1:0] rid,
                                          input logic last);
        t_result r;
        r.status = st;
        r.rid    = rid;
        r.last   = last;
        return r;
    endfunction

    function automatic t_plan_row row(input logic c, input logic [ID_W-1:0] pid,
                                      input logic [WAIT_W-1:0] wt, input logic cr,
                                      input logic by_hand, input t_status st);
        t_plan_row r;
        r.cmd         = c;
        r.pid         = pid;
        r.sleep_ticks = wt;
        r.credit      = cr;
        r.by_hand     = by_hand;
        r.status      = st;
        return r;
    endfunction

    // Apply one transferred item to the predicted table and fill item_results.
    task automatic advance_table(input logic c, input logic [ID_W-1:0] pid,
                                 input logic [WAIT_W-1:0] wt, input logic cr);
        t_sleeper        s;
        t_sleeper        kept[$];
        logic [ID_W-1:0] freed[$];
        int              k;
        item_results.delete();
        if (c == CMD_BLOCK) begin
            if (sleepers.size() >= TABLE_SLOTS) begin
                // full table: reject, leave the table as it is
                item_results.push_back(mk_result(ST_FULL, '0, 1'b1));
            end else begin
                s.pid        = pid;
                s.ticks_left = wt[TIME_BITS_DEF-1:0];
                s.credit     = cr;
                sleepers.push_back(s);
                item_results.push_back(mk_result(ST_ACCEPT, '0, 1'b1));
            end
        end else begin
            // Walk newest first: count down with a floor at zero, release credited
            // entries that sit at zero. Survivors are rebuilt oldest first.
            for (k = sleepers.size() - 1; k >= 0; k--) begin
                s = sleepers[k];
                if (s.ticks_left != 0)
                    s.ticks_left = s.ticks_left - 1'b1;
                if (s.ticks_left == 0 && s.credit)
                    freed.push_back(s.pid);
                else
                    kept.push_front(s);
            end
            sleepers = kept;
            if (freed.size() == 0)
                item_results.push_back(mk_result(ST_NONE, '0, 1'b1));
            for (k = 0; k < freed.size(); k++)
                item_results.push_back(mk_result(ST_RELEASE, freed[k], k == freed.size() - 1));
        end
    endtask

    // Offer one item in the sender's burst rhythm, hold it until the transfer,
    // then record what the block owes for it.
    task automatic transfer_item(input logic c, input logic [ID_W-1:0] pid,
                                 input logic [WAIT_W-1:0] wt, input logic cr,
                                 input logic by_hand, input t_status st);
        int gap;
        int k;
        @(negedge i_clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 10);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_in_valid    <= 1'b1;
        i_cmd         <= c;
        i_process_id  <= pid;
        i_sleep_ticks <= wt;
        i_has_credit  <= cr;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        advance_table(c, pid, wt, cr);
        if (by_hand)
            due_results.push_back(mk_result(st, '0, 1'b1));
        else
            for (k = 0; k < item_results.size(); k++)
                due_results.push_back(item_results[k]);
    endtask

    initial begin : stimulus
        int                n;
        int                j;
        int                block_pct;
        int                stuck;
        logic              c;
        logic [ID_W-1:0]   pid;
        logic [WAIT_W-1:0] wt;
        logic              cr;

        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_cmd         = CMD_BLOCK;
        i_process_id  = '0;
        i_sleep_ticks = '0;
        i_has_credit  = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table
        // tick on an empty table releases nothing
        plan.push_back(row(CMD_TICK,  8'h00, 16'h0000, 1'b0, 1'b1, ST_NONE));
        // zero wait with credit: released by the very next tick
        plan.push_back(row(CMD_BLOCK, 8'h00, 16'h0000, 1'b1, 1'b1, ST_ACCEPT));
        plan.push_back(row(CMD_TICK,  8'h00, 16'h0000, 1'b0, 1'b0, ST_NONE));
        // top id, top wait, no credit: stays for the whole run
        plan.push_back(row(CMD_BLOCK, 8'hFF, 16'hFFFF, 1'b0, 1'b1, ST_ACCEPT));
        plan.push_back(row(CMD_BLOCK, 8'hA5, 16'h0001, 1'b1, 1'b1, ST_ACCEPT));
        // no credit: parks at zero and is never released
        plan.push_back(row(CMD_BLOCK, 8'h5A, 16'h0002, 1'b0, 1'b1, ST_ACCEPT));
        // tick with junk in the ignored fields
        plan.push_back(row(CMD_TICK,  8'hFF, 16'hFFFF, 1'b1, 1'b0, ST_NONE));
        plan.push_back(row(CMD_TICK,  8'h00, 16'h0000, 1'b0, 1'b0, ST_NONE));
        // fill the remaining slots with entries due on the next tick
        for (j = 0; j < TABLE_SLOTS - 2; j++)
            plan.push_back(row(CMD_BLOCK, ID_W'(8'h10 + j), WAIT_W'(j % 2), 1'b1, 1'b1,
                               ST_ACCEPT));
        // full table rejects
        plan.push_back(row(CMD_BLOCK, 8'h77, 16'h0003, 1'b1, 1'b1, ST_FULL));
        // many releases on one tick, then the parked entries alone
        plan.push_back(row(CMD_TICK,  8'h00, 16'h0000, 1'b0, 1'b0, ST_NONE));
        plan.push_back(row(CMD_TICK,  8'h00, 16'h0000, 1'b0, 1'b0, ST_NONE));

        for (n = 0; n < plan.size(); n++)
            transfer_item(plan[n].cmd, plan[n].pid, plan[n].sleep_ticks, plan[n].credit,
                          plan[n].by_hand, plan[n].status);

        // Random part: phases lean toward blocks (fill, hit full) or ticks (drain)
        block_pct = 60;
        for (n = 0; n < RAND_ITEMS; n++) begin
            if (n % 20 == 0)
                block_pct = $urandom_range(0, 1) ? 80 : 40;
            stuck = 0;
            for (j = 0; j < sleepers.size(); j++)
                if (!sleepers[j].credit || sleepers[j].ticks_left > SHORT_WAIT)
                    stuck++;
            c   = ($urandom_range(0, 99) < block_pct) ? CMD_BLOCK : CMD_TICK;
            pid = ID_W'($urandom);
            if (stuck < STUCK_CAP && $urandom_range(0, 11) == 0) begin
                // rare entry that never leaves: no credit, or a very long wait
                cr = 1'($urandom);
                wt = cr ? WAIT_W'($urandom_range(LONG_WAIT, 65535)) : WAIT_W'($urandom);
            end else begin
                cr = 1'b1;
                wt = WAIT_W'($urandom_range(0, SHORT_WAIT));
            end
            transfer_item(c, pid, wt, cr, 1'b0, ST_NONE);
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;

        // Drain: wait for every owed result, then watch for strays
        while (due_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (n_bad == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Receiver: stall on a rotating pattern that is redrawn now and then;
    // an all-ones pattern gives stretches with no stall.
    initial begin : result_sink
        logic [15:0] ready_pat;
        int          pat_left;
        i_out_ready = 1'b0;
        ready_pat   = '1;
        pat_left    = 0;
        forever begin
            @(negedge i_clk);
            if (!hold_done && n_checked >= HOLD_AT) begin
                // hold off long enough that the block backs up and drops o_in_ready
                hold_done = 1'b1;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            if (pat_left == 0) begin
                case ($urandom_range(0, 2))
                    0: ready_pat = '1;
                    1: ready_pat = 16'($urandom);
                    default: ready_pat = 16'($urandom | $urandom);
                endcase
                pat_left = $urandom_range(16, 80);
            end
            i_out_ready <= ready_pat[0];
            ready_pat = {ready_pat[0], ready_pat[15:1]};
            pat_left--;
        end
    end

    // Compare each result transfer with the oldest owed result
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_checked++;
            if (due_results.size() == 0) begin
                n_bad++;
                if (n_bad <= MAX_REPORTS)
                    $display("unexpected result: status=%0d id=%02h last=%0b",
                             o_status, o_released_id, o_last);
            end else begin
                want = due_results.pop_front();
                if (o_status !== want.status || o_released_id !== want.rid ||
                    o_last !== want.last) begin
                    n_bad++;
                    if (n_bad <= MAX_REPORTS)
                        $display("mismatch: want %0d/%02h/%0b got %0d/%02h/%0b",
                                 want.status, want.rid, want.last,
                                 o_status, o_released_id, o_last);
                end
            end
        end
    end

    // Watchdog: end the run when no transfer happens on either channel for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

// ----- sim.f -----
hw/rtl/bpwt_pkg.sv
hw/rtl/bpwt_ram.sv
hw/rtl/bpwt_ctrl.sv
hw/rtl/bpwt_dp.sv
hw/rtl/blocked_process_wait_table.sv
verif/blocked_process_wait_table_tb.sv
